>>> rtl/core/ksa_pkg.sv
// Shared types for the keyed slot allocator: request opcodes and result outcome codes.
// No dependencies; imported by keyed_slot_allocator_unit.
package ksa_pkg;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    OUT_HIT          = 3'd0,
    OUT_INSERTED     = 3'd1,
    OUT_FULL         = 3'd2,
    OUT_NULL         = 3'd3,
    OUT_RELEASED     = 3'd4,
    OUT_RELEASE_MISS = 3'd5
  } outcome_t;

endpackage

>>> rtl/core/keyed_slot_allocator_unit.sv
// Keyed slot allocator: a table of keys in one single-port synchronous memory,
// searched slot by slot for each request. Depends on ksa_pkg.
//
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_ready  opcode, key
// out      source     out_valid/out_ready  slot_index, inserted, outcome
//
// An item with a nonzero key goes from acceptance to a registered result as
// follows: the single memory port reads slots 1 to CAPACITY-1 one per cycle,
// the last read returns in ST_DRAIN, ST_DECIDE decides and makes any write, and
// ST_DONE loads the result register once the output is free. Input is ready
// again in the cycle after that; a new item is not taken before the last is done.
// An item with the null key skips the search.
// After reset the memory is swept to zero, one slot per cycle; no item is
// accepted during the sweep.
// One item is in flight at a time. The result register lets the next item be
// accepted while a finished result still waits; a stalled result only holds
// back the following result.
module keyed_slot_allocator_unit #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32,
  localparam int SW       = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ksa_pkg::opcode_t      opcode,
  input  logic [KEY_WIDTH-1:0]  key,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SW-1:0]         slot_index,
  output logic                  inserted,
  output ksa_pkg::outcome_t     outcome
);
  import ksa_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0] FIRST = IW'(1);
  localparam logic [IW-1:0] LAST  = IW'(CAPACITY - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  // The key table. Slot 0 is never written after the sweep, so it stays empty.
  logic [KEY_WIDTH-1:0] mem [CAPACITY];
  logic [KEY_WIDTH-1:0] rdata;
  logic                 mem_we;
  logic [IW-1:0]        mem_addr;
  logic [KEY_WIDTH-1:0] mem_wdata;

  // One counter walks the memory both for the reset sweep and for each search.
  logic [IW-1:0] cnt;

  // The item being served.
  opcode_t              op_q;
  logic [KEY_WIDTH-1:0] key_q;

  // Read tracking: a read issued in one cycle returns data in the next.
  logic          rd_pend;
  logic [IW-1:0] rd_slot;

  // Lowest slot holding the key, and lowest empty slot, found so far.
  logic          hit_found, free_found;
  logic [IW-1:0] hit_slot, free_slot;

  // Decision made at the end of the search.
  logic          dec_write;
  logic [IW-1:0] dec_addr;
  logic [KEY_WIDTH-1:0] dec_wdata;
  logic [SW-1:0] dec_slot;
  logic          dec_ins;
  outcome_t      dec_outcome;

  // Result waiting for the output register.
  logic [SW-1:0] res_slot;
  logic          res_ins;
  outcome_t      res_outcome;

  logic in_fire;
  logic out_free;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    dec_write   = 1'b0;
    dec_addr    = hit_slot;
    dec_wdata   = '0;
    dec_slot    = '0;
    dec_ins     = 1'b0;
    dec_outcome = OUT_NULL;
    if (op_q == OP_ACQUIRE) begin
      if (key_q == '0) begin
        dec_outcome = OUT_NULL;
      end else if (hit_found) begin
        dec_slot    = SW'(hit_slot);
        dec_outcome = OUT_HIT;
      end else if (free_found) begin
        dec_write   = 1'b1;
        dec_addr    = free_slot;
        dec_wdata   = key_q;
        dec_slot    = SW'(free_slot);
        dec_ins     = 1'b1;
        dec_outcome = OUT_INSERTED;
      end else begin
        dec_outcome = OUT_FULL;
      end
    end else begin
      // A release of the null key never searches, so hit_found stays clear.
      if (key_q != '0 && hit_found) begin
        dec_write   = 1'b1;
        dec_addr    = hit_slot;
        dec_slot    = SW'(hit_slot);
        dec_outcome = OUT_RELEASED;
      end else begin
        dec_slot    = SW'(CAPACITY);
        dec_outcome = OUT_RELEASE_MISS;
      end
    end
  end

  // Memory port: sweep writes, search reads, or the single write of a decision.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cnt;
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == ST_DECIDE) begin
      mem_we    = dec_write;
      mem_addr  = dec_addr;
      mem_wdata = dec_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (cnt == LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (key == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN:   if (cnt == LAST) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_SCAN);
      if (state == ST_CLEAR || state == ST_SCAN) begin
        cnt <= cnt + IW'(1);
      end else if (in_fire) begin
        cnt <= FIRST;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q  <= opcode;
      key_q <= key;
    end
    if (state == ST_SCAN) begin
      rd_slot <= cnt;
    end
    if (rd_pend) begin
      if (!hit_found && rdata == key_q) begin
        hit_found <= 1'b1;
        hit_slot  <= rd_slot;
      end
      if (!free_found && rdata == '0) begin
        free_found <= 1'b1;
        free_slot  <= rd_slot;
      end
    end
    if (in_fire) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end
    if (state == ST_DECIDE) begin
      res_slot    <= dec_slot;
      res_ins     <= dec_ins;
      res_outcome <= dec_outcome;
    end
    if (state == ST_DONE && out_free) begin
      slot_index <= res_slot;
      inserted   <= res_ins;
      outcome    <= res_outcome;
    end
  end

  // Slot 0 is the fallback and must never receive a key after the sweep.
  a_no_slot0_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != ST_CLEAR) |-> (mem_addr != '0))
    else $error("write to fallback slot outside the reset sweep");

  // Read data is only consumed while a search is running.
  a_read_in_search: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("read return outside a search");

  // A new item is never taken while the previous one is still being decided.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) |=> !in_ready)
    else $error("input ready while a result is pending");

  // Released and inserted slots are always real slots, never the fallback.
  a_real_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == OUT_RELEASED || outcome == OUT_INSERTED))
      |-> (slot_index != '0 && slot_index != SW'(CAPACITY)))
    else $error("released or inserted result names a non-storage slot");

endmodule

>>> test/keyed_slot_allocator_unit_tb.sv
// Self-checking testbench for keyed_slot_allocator_unit: drives acquire and release items
// and checks every result against a slot-table predictor kept inside the bench.
// Depends on ksa_pkg and the keyed_slot_allocator_unit RTL.
`timescale 1ns / 1ps

module keyed_slot_allocator_unit_tb;
  import ksa_pkg::*;

  localparam int CAPACITY  = 256;
  localparam int KEY_W     = 32;
  localparam int SLOT_W    = $clog2(CAPACITY + 1);
  localparam int POOL_SIZE = 280;   // a bit more keys than free slots, so the table fills up
  localparam int MAX_REPORTS = 10;

  // One expected result: the slot handed out (or released) and how the request ended.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              ins;
    outcome_t          outcome;
  } grant_t;

  // Shadow copy of the slot table. Every accepted item updates it in order and leaves
  // its expected result in a queue; results from the block are matched in order.
  class slot_table_tracker;
    logic [KEY_W-1:0] held_key [CAPACITY];
    grant_t           pending_grants [$];
    int               mismatches;
    int               grants_checked;
    int               outcome_count [6];

    function new();
      foreach (held_key[i]) held_key[i] = '0;
      foreach (outcome_count[i]) outcome_count[i] = 0;
      mismatches     = 0;
      grants_checked = 0;
    endfunction

    // Lowest slot from 1 upward that holds the key; CAPACITY when there is none.
    // Looking up the zero key finds the lowest empty slot.
    function int lookup(logic [KEY_W-1:0] k);
      for (int i = 1; i < CAPACITY; i++) begin
        if (held_key[i] == k) return i;
      end
      return CAPACITY;
    endfunction

    function grant_t predict_grant(opcode_t op, logic [KEY_W-1:0] k);
      grant_t g;
      int     s;
      g.slot    = '0;
      g.ins     = 1'b0;
      g.outcome = OUT_NULL;
      if (op == OP_ACQUIRE) begin
        if (k != '0) begin
          s = lookup(k);
          if (s < CAPACITY) begin
            g.slot    = SLOT_W'(s);
            g.outcome = OUT_HIT;
          end else begin
            s = lookup('0);
            if (s < CAPACITY) begin
              held_key[s] = k;
              g.slot      = SLOT_W'(s);
              g.ins       = 1'b1;
              g.outcome   = OUT_INSERTED;
            end else begin
              g.outcome = OUT_FULL;
            end
          end
        end
      end else begin
        // A release of the null key or of an absent key leaves the table alone.
        g.slot    = SLOT_W'(CAPACITY);
        g.outcome = OUT_RELEASE_MISS;
        if (k != '0) begin
          s = lookup(k);
          if (s < CAPACITY) begin
            held_key[s] = '0;
            g.slot      = SLOT_W'(s);
            g.outcome   = OUT_RELEASED;
          end
        end
      end
      return g;
    endfunction

    function void note_request(opcode_t op, logic [KEY_W-1:0] k);
      grant_t g;
      g = predict_grant(op, k);
      outcome_count[int'(g.outcome)]++;
      pending_grants.push_back(g);
    endfunction

    function void check_grant(logic [SLOT_W-1:0] slot, logic ins, outcome_t outc);
      grant_t want;
      grants_checked++;
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result slot=%0d inserted=%0d outcome=%0d",
                   slot, ins, outc);
        return;
      end
      want = pending_grants.pop_front();
      if (slot !== want.slot || ins !== want.ins || outc !== want.outcome) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result %0d: expected slot=%0d inserted=%0d outcome=%0d, got slot=%0d inserted=%0d outcome=%0d",
                   grants_checked, want.slot, want.ins, want.outcome, slot, ins, outc);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  opcode_t           opcode;
  logic [KEY_W-1:0]  key;
  logic              out_valid;
  logic              out_ready;
  logic [SLOT_W-1:0] slot_index;
  logic              inserted;
  outcome_t          outcome;

  // Per-cycle idle chances in percent; the stimulus process changes them per phase.
  int                send_idle_pct;
  int                recv_idle_pct;
  int                requests_sent;
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];
  slot_table_tracker tracker;

  keyed_slot_allocator_unit #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot_index(slot_index),
    .inserted  (inserted),
    .outcome   (outcome)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Presents one item, starting at a falling edge. It may first idle for a few cycles,
  // then holds valid and the payload until the item is taken at a rising edge, and
  // returns at the following falling edge. Valid is only ever written once per edge.
  task automatic send_item(input opcode_t op, input logic [KEY_W-1:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode   = op;
    key      = k;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(op, k);
    requests_sent++;
    @(negedge clk);
  endtask

  // Any key: usually from the pool, now and then the null key or a fresh random one.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 80) return key_pool[$urandom_range(POOL_SIZE - 1)];
    if (r < 90) return '0;
    return $urandom;
  endfunction

  // One random phase. It is built from well-formed work: a fill pass that walks the
  // key pool with acquires so that the table runs full, a churn section of mixed
  // acquires and releases on pool keys, and a drain pass that walks the pool with
  // releases. Each part is salted with null keys, random keys and random opcodes.
  task automatic run_phase(input int send_idle, input int recv_idle);
    int start;
    int r;
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    start = $urandom_range(POOL_SIZE - 1);
    for (int n = 0; n < 330; n++) begin
      r = $urandom_range(99);
      if (r < 85)      send_item(OP_ACQUIRE, key_pool[(start + n) % POOL_SIZE]);
      else if (r < 90) send_item(OP_ACQUIRE, '0);
      else if (r < 95) send_item(OP_RELEASE, key_pool[$urandom_range(POOL_SIZE - 1)]);
      else             send_item(opcode_t'($urandom_range(1)), $urandom);
    end
    for (int n = 0; n < 120; n++) begin
      r = $urandom_range(99);
      if (r < 90) send_item(opcode_t'(r % 2), key_pool[$urandom_range(POOL_SIZE - 1)]);
      else        send_item(opcode_t'($urandom_range(1)), pick_key());
    end
    start = $urandom_range(POOL_SIZE - 1);
    for (int n = 0; n < 110; n++) begin
      r = $urandom_range(99);
      if (r < 85) send_item(OP_RELEASE, key_pool[(start + n) % POOL_SIZE]);
      else        send_item(opcode_t'($urandom_range(1)), pick_key());
    end
  endtask

  // Result side: sample at the rising edge, choose ready for the next cycle at the
  // falling edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        tracker.check_grant(slot_index, inserted, outcome);
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    tracker       = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    opcode        = OP_ACQUIRE;
    key           = '0;
    requests_sent = 0;
    send_idle_pct = 37;
    recv_idle_pct = 49;

    // The pool holds the key extremes plus random nonzero keys.
    key_pool[0] = '1;
    key_pool[1] = KEY_W'(1);
    key_pool[2] = {1'b1, {(KEY_W - 1){1'b0}}};
    key_pool[3] = {1'b0, {(KEY_W - 1){1'b1}}};
    for (int i = 4; i < POOL_SIZE; i++) begin
      do key_pool[i] = $urandom; while (key_pool[i] == '0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed opening on an empty table: null keys on both opcodes, a release that
    // finds nothing, inserts at the key extremes, a hit, reuse of the lowest freed
    // slot, a repeated release that misses, and a clean drain back to empty.
    // The table-full case needs over two hundred inserts and comes in the fill passes.
    send_item(OP_ACQUIRE, '0);
    send_item(OP_RELEASE, '0);
    send_item(OP_RELEASE, 32'hDEAD_BEEF);
    send_item(OP_ACQUIRE, '1);
    send_item(OP_ACQUIRE, 32'h0000_0001);
    send_item(OP_ACQUIRE, 32'h8000_0000);
    send_item(OP_ACQUIRE, '1);
    send_item(OP_RELEASE, 32'h0000_0001);
    send_item(OP_ACQUIRE, 32'h0000_0002);
    send_item(OP_RELEASE, 32'h0000_0001);
    send_item(OP_RELEASE, '1);
    send_item(OP_ACQUIRE, 32'h7FFF_FFFF);
    send_item(OP_ACQUIRE, 32'h8000_0000);
    send_item(OP_RELEASE, 32'h0000_0002);
    send_item(OP_RELEASE, 32'h8000_0000);
    send_item(OP_RELEASE, 32'h7FFF_FFFF);

    // Receiver-heavy idling, then sender-heavy idling, then full rate on both sides.
    run_phase(37, 49);
    run_phase(49, 37);
    run_phase(0, 0);
    in_valid = 1'b0;

    // Let every result come back, then keep watching for stray output.
    while (tracker.pending_grants.size() != 0) @(posedge clk);
    repeat (CAPACITY + 40) @(posedge clk);

    $display("Sent %0d acquire/release items under three idle patterns; checked %0d results.",
             requests_sent, tracker.grants_checked);
    $display("Outcomes: hit %0d, insert %0d, table full %0d, null key %0d, released %0d, release miss %0d.",
             tracker.outcome_count[OUT_HIT], tracker.outcome_count[OUT_INSERTED],
             tracker.outcome_count[OUT_FULL], tracker.outcome_count[OUT_NULL],
             tracker.outcome_count[OUT_RELEASED], tracker.outcome_count[OUT_RELEASE_MISS]);
    if (tracker.mismatches == 0 && tracker.pending_grants.size() == 0) begin
      $display("keyed_slot_allocator_unit: match");
    end else begin
      $display("%0d results failed their checks.", tracker.mismatches);
      $display("keyed_slot_allocator_unit: mismatch");
    end
    $finish;
  end

  // Watchdog: a correct run needs about 2 ms, including the memory sweep after reset.
  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", tracker.pending_grants.size());
    $display("keyed_slot_allocator_unit: mismatch");
    $finish;
  end

endmodule
